/* src/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SITD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define SITD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* src/sitd_pkg.sv */
// Types and constants for the signed integer to decimal text unit.
`timescale 1ns / 1ps

package sitd_pkg;

  localparam int MAX_WIDTH  = 32;
  localparam int VALUE_W    = 64;
  localparam int NUM_DIGITS = 20;
  localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
  localparam int DCNT_W     = $clog2(NUM_DIGITS + 1);
  localparam int BCNT_W     = $clog2(VALUE_W);

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef struct packed {
    logic signed [63:0] value;
    logic [5:0]         pad_width;
    logic [7:0]         fill_char;
  } in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } out_t;

  // Control shared by every digit cell in the chain.
  typedef struct packed {
    logic clear;   // zero the digit
    logic dabble;  // add-3 correction, then shift one bit in
    logic move;    // take the neighbor's digit
  } cell_ctrl_t;

endpackage

/* src/sitd_bcd_cell.sv */
// One BCD digit cell of the shift-and-add-3 chain.
`timescale 1ns / 1ps

module sitd_bcd_cell (
  input  logic                clk,
  input  sitd_pkg::cell_ctrl_t ctrl,
  input  logic                bit_in,
  input  logic [3:0]          digit_in,
  output logic [3:0]          digit,
  output logic                carry
);

  logic [3:0] adj;

  assign adj   = (digit >= 4'd5) ? (digit + 4'd3) : digit;
  assign carry = adj[3];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= 4'd0;
    end else if (ctrl.dabble) begin
      digit <= {adj[2:0], bit_in};
    end else if (ctrl.move) begin
      digit <= digit_in;
    end
  end

endmodule

/* src/sitd_bcd_chain.sv */
// Row of BCD digit cells; bits enter at the low digit, digits leave at the top.
`timescale 1ns / 1ps

module sitd_bcd_chain (
  input  logic                clk,
  input  sitd_pkg::cell_ctrl_t ctrl,
  input  logic                bit_in,
  output logic [3:0]          top_digit
);

  logic [3:0] digits [sitd_pkg::NUM_DIGITS];
  logic       carry  [sitd_pkg::NUM_DIGITS];

  assign carry[0] = bit_in;

  for (genvar i = 0; i < sitd_pkg::NUM_DIGITS; i++) begin : g_cell
    logic [3:0] din;
    if (i == 0) begin : g_first
      assign din = 4'd0;
    end else begin : g_rest
      assign din = digits[i-1];
    end
    if (i < sitd_pkg::NUM_DIGITS - 1) begin : g_mid
      sitd_bcd_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .bit_in   (carry[i]),
        .digit_in (din),
        .digit    (digits[i]),
        .carry    (carry[i+1])
      );
    end else begin : g_top
      // a 64-bit magnitude never carries out of the top digit
      sitd_bcd_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .bit_in   (carry[i]),
        .digit_in (din),
        .digit    (digits[i]),
        .carry    ()
      );
    end
  end

  assign top_digit = digits[sitd_pkg::NUM_DIGITS-1];

endmodule

/* src/signed_int_to_decimal_ascii_unit.sv */
// Top level: signed 64-bit integer to left-padded decimal ASCII text.
`timescale 1ns / 1ps

// Usage
//   Input: drive item and raise start; the transfer happens at a rising
//   edge with start high and busy low. busy stays high until the last
//   character of the conversion has been issued.
//   Output: one character per cycle on result, marked by strobe for one
//   cycle each; result.last flags the final character. The receiver
//   cannot stall, so characters of one conversion come out back to back.
//   Steps: the magnitude is shifted bit by bit through a row of 20 BCD
//   cells (double dabble), then leading zero digits are dropped so the
//   top digit is aligned, then N = max(text length, width) characters
//   are issued: fill characters, then the sign, then the digits.
//   The next item may be taken in the cycle the last character shows.
//   Reset: synchronous rst returns to idle and drops strobe; the digit
//   cells are cleared at the start of every conversion.
module signed_int_to_decimal_ascii_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  sitd_pkg::in_t  item,
  output logic           busy,
  output logic           strobe,
  output sitd_pkg::out_t result
);

  typedef enum logic [1:0] {IDLE, CONV, NORM, EMIT} state_t;

  state_t                           state;
  logic [sitd_pkg::VALUE_W-1:0]     mag;
  logic [sitd_pkg::BCNT_W-1:0]      bcnt;
  logic [sitd_pkg::DCNT_W-1:0]      ndig;
  logic                             neg;
  logic                             sign_pend;
  logic [7:0]                       fill;
  logic [sitd_pkg::WIDTH_W-1:0]     width;
  logic [sitd_pkg::WIDTH_W-1:0]     pad_left;
  logic [sitd_pkg::WIDTH_W-1:0]     rem;

  sitd_pkg::cell_ctrl_t             ctrl;
  logic [3:0]                       top_digit;
  logic                             accept;
  logic                             drop_zero;
  logic                             emit_digit;
  logic [sitd_pkg::WIDTH_W-1:0]     tlen;
  logic [sitd_pkg::WIDTH_W-1:0]     pad_calc;

  assign accept     = start && (state == IDLE);
  assign drop_zero  = (state == NORM) && (top_digit == 4'd0) &&
                      (ndig > sitd_pkg::DCNT_W'(1));
  assign emit_digit = (state == EMIT) && (pad_left == '0) && !sign_pend;

  assign ctrl.clear  = accept;
  assign ctrl.dabble = (state == CONV);
  assign ctrl.move   = drop_zero || emit_digit;

  // text length = digits + optional sign
  assign tlen     = sitd_pkg::WIDTH_W'(ndig) + sitd_pkg::WIDTH_W'(neg);
  assign pad_calc = (width > tlen) ? (width - tlen) : '0;

  assign busy = (state != IDLE);

  sitd_bcd_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .bit_in    (mag[sitd_pkg::VALUE_W-1]),
    .top_digit (top_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            neg  <= item.value[63];
            mag  <= item.value[63] ? (64'd0 - item.value) : item.value;
            fill <= item.fill_char;
            // width saturates at MAX_WIDTH
            width <= (int'(item.pad_width) > sitd_pkg::MAX_WIDTH) ?
                     sitd_pkg::WIDTH_W'(sitd_pkg::MAX_WIDTH) :
                     sitd_pkg::WIDTH_W'(item.pad_width);
            bcnt  <= '0;
            state <= CONV;
          end
        end
        CONV: begin
          mag  <= mag << 1;
          bcnt <= bcnt + sitd_pkg::BCNT_W'(1);
          if (bcnt == sitd_pkg::BCNT_W'(sitd_pkg::VALUE_W - 1)) begin
            ndig  <= sitd_pkg::DCNT_W'(sitd_pkg::NUM_DIGITS);
            state <= NORM;
          end
        end
        NORM: begin
          if (drop_zero) begin
            ndig <= ndig - sitd_pkg::DCNT_W'(1);
          end else begin
            pad_left  <= pad_calc;
            sign_pend <= neg;
            rem       <= pad_calc + tlen;
            state     <= EMIT;
          end
        end
        EMIT: begin
          strobe      <= 1'b1;
          result.last <= (rem == sitd_pkg::WIDTH_W'(1));
          rem         <= rem - sitd_pkg::WIDTH_W'(1);
          if (pad_left != '0) begin
            result.char_code <= fill;
            pad_left         <= pad_left - sitd_pkg::WIDTH_W'(1);
          end else if (sign_pend) begin
            result.char_code <= sitd_pkg::ASCII_MINUS;
            sign_pend        <= 1'b0;
          end else begin
            result.char_code <= sitd_pkg::ASCII_ZERO + {4'd0, top_digit};
          end
          if (rem == sitd_pkg::WIDTH_W'(1)) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* src/sitd_checker.sv */
// Port-level checker for the decimal text unit, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sitd_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           strobe,
  input sitd_pkg::out_t result
);

  // an accepted item keeps the unit busy for the conversion
  `SITD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // no character appears in the cycle after a transfer in
  `SITD_ASSERT_NEXT(a_accept_quiet, start && !busy, !strobe)
  // characters of one conversion come without gaps
  `SITD_ASSERT_NEXT(a_no_gap, strobe && !result.last, strobe)
  // the final character finds the unit ready for a new item
  `SITD_ASSERT_SAME(a_last_idle, strobe && result.last, !busy)

endmodule

bind signed_int_to_decimal_ascii_unit sitd_checker u_sitd_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

/* tb/sitd_scoreboard_pkg.sv */
// Scoreboard for the decimal text unit: predicts the characters and checks each result.
`timescale 1ns / 1ps

package sitd_scoreboard_pkg;

  import sitd_pkg::*;

  class text_scoreboard;

    out_t expected_chars[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    // One line per mismatch, and a count.
    function void report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // Work out the full character sequence of one accepted input transfer.
    function void note_item(in_t it);
      logic [63:0] mag;
      logic        neg;
      logic [7:0]  rev_digits[20];
      logic [7:0]  text[21];
      int          ndig;
      int          tlen;
      int          width;
      int          pad;
      int          total;
      out_t        ch;
      neg  = it.value[63];
      mag  = neg ? (64'd0 - it.value) : it.value;
      ndig = 0;
      do begin
        rev_digits[ndig] = ASCII_ZERO + 8'(mag % 64'd10);
        mag = mag / 64'd10;
        ndig++;
      end while (mag != 64'd0);
      tlen = 0;
      if (neg) begin
        text[0] = ASCII_MINUS;
        tlen = 1;
      end
      for (int k = 0; k < ndig; k++) begin
        text[tlen] = rev_digits[ndig - 1 - k];
        tlen++;
      end
      width = int'(it.pad_width);
      if (width > MAX_WIDTH) width = MAX_WIDTH;
      pad   = (width > tlen) ? width - tlen : 0;
      total = pad + tlen;
      for (int k = 0; k < total; k++) begin
        ch.char_code = (k < pad) ? it.fill_char : text[k - pad];
        ch.last      = (k == total - 1);
        expected_chars.push_back(ch);
      end
    endfunction

    function void check_char(out_t got);
      out_t want;
      if (expected_chars.size() == 0) begin
        report($sformatf("character 0x%02h with nothing pending", got.char_code));
        return;
      end
      want = expected_chars.pop_front();
      if (got.char_code !== want.char_code)
        report($sformatf("char_code 0x%02h, predicted 0x%02h", got.char_code, want.char_code));
      if (got.last !== want.last)
        report($sformatf("last %b, predicted %b (char 0x%02h)", got.last, want.last,
                         want.char_code));
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

  endclass

endpackage

/* tb/tb_top.sv */
// Top of the testbench for signed_int_to_decimal_ascii_unit: stimulus, monitor, end of run.
`timescale 1ns / 1ps

module tb_top;

  import sitd_pkg::*;
  import sitd_scoreboard_pkg::*;

  localparam int N_RANDOM   = 400;
  // Random items in this index range go in back to back, no idle cycles.
  localparam int QUIET_LO   = 150;
  localparam int QUIET_HI   = 260;
  localparam int DRAIN_WAIT = 150;

  logic clk;
  logic rst;
  logic start;
  in_t  item;
  logic busy;
  logic strobe;
  out_t result;

  text_scoreboard sb;

  signed_int_to_decimal_ascii_unit dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a correct run needs well under 2 ms.
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Monitor: everything sampled on the rising edge, before the block updates.
  // A result strobe and a new input transfer may share one edge; the
  // result belongs to the older item, which is already queued ahead.
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) sb.check_char(result);
      if (start && !busy) sb.note_item(item);
    end
  end

  function automatic in_t make_item(logic [63:0] v, int w, int f);
    in_t it;
    it.value     = v;
    it.pad_width = 6'(w);
    it.fill_char = 8'(f);
    return it;
  endfunction

  // Junk for the item bus while start is low.
  function automatic in_t noise_item();
    return make_item({$urandom, $urandom}, $urandom_range(0, 63), $urandom_range(0, 255));
  endfunction

  function automatic logic [63:0] pow10(int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) p = p * 64'd10;
    return p;
  endfunction

  // Mix of full-range words, small numbers, every digit count and the edges.
  function automatic logic [63:0] rand_value();
    logic [63:0] base;
    logic [63:0] mag;
    int          k;
    case ($urandom_range(0, 3))
      0: mag = {$urandom, $urandom};
      1: mag = 64'($urandom_range(0, 999));
      2: begin
        k    = $urandom_range(1, 19);
        base = pow10(k - 1);
        mag  = base + ({$urandom, $urandom} % (base * 64'd9));
      end
      default: begin
        case ($urandom_range(0, 2))
          0: mag = 64'h8000_0000_0000_0000 - 64'($urandom_range(0, 20));
          1: mag = 64'h7fff_ffff_ffff_ffff - 64'($urandom_range(0, 20));
          default: mag = pow10($urandom_range(0, 18)) + 64'($urandom_range(0, 2)) - 64'd1;
        endcase
      end
    endcase
    if ($urandom_range(0, 1) == 1) mag = 64'd0 - mag;
    return mag;
  endfunction

  function automatic int rand_width();
    if ($urandom_range(0, 9) == 0) return $urandom_range(33, 63);
    return $urandom_range(0, 32);
  endfunction

  // One input transfer. Optional idle cycles first, then hold start high
  // until the block takes the item. start stays high between back-to-back
  // items, so it is never lowered and raised in the same step.
  task automatic send_item(input in_t it, input bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 99) < 15) begin
      // mostly short gaps, some long enough to outlast a conversion
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 130) : $urandom_range(1, 5);
      @(negedge clk);
      start <= 1'b0;
      item  <= noise_item();
      repeat (gap - 1) begin
        @(negedge clk);
        item <= noise_item();
      end
    end
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    sb    = new();
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed: zero, single digits, sign, digit-count edges, the two
    // extremes of value, and every width corner (none, exact, over, saturating).
    send_item(make_item(64'd0, 0, 8'h20), 1'b0);
    send_item(make_item(64'd0, 32, 8'h30), 1'b0);
    send_item(make_item(64'd1, 1, 8'h2a), 1'b0);
    send_item(make_item(-64'sd1, 2, 8'h20), 1'b0);
    send_item(make_item(64'd9, 3, 8'h00), 1'b0);
    send_item(make_item(64'd10, 2, 8'hff), 1'b0);
    send_item(make_item(-64'sd10, 4, 8'h5f), 1'b0);
    send_item(make_item(64'h7fff_ffff_ffff_ffff, 0, 8'h20), 1'b0);
    send_item(make_item(64'h7fff_ffff_ffff_ffff, 20, 8'h20), 1'b0);
    send_item(make_item(64'h8000_0000_0000_0000, 0, 8'h20), 1'b0);
    send_item(make_item(64'h8000_0000_0000_0000, 20, 8'h2e), 1'b0);
    send_item(make_item(64'h8000_0000_0000_0000, 21, 8'h2e), 1'b0);
    send_item(make_item(64'h8000_0000_0000_0000, 63, 8'hff), 1'b0);
    send_item(make_item(64'h8000_0000_0000_0001, 32, 8'h00), 1'b0);
    send_item(make_item(pow10(18), 19, 8'h20), 1'b0);
    send_item(make_item(pow10(18) - 64'd1, 19, 8'h20), 1'b0);
    send_item(make_item(pow10(18) + 64'd1, 33, 8'h23), 1'b0);
    send_item(make_item(64'd0 - pow10(18), 18, 8'h20), 1'b0);
    send_item(make_item(64'd12345, 33, 8'h30), 1'b0);
    send_item(make_item(64'd12345, 63, 8'h30), 1'b0);
    send_item(make_item(-64'sd42, 32, 8'h80), 1'b0);
    send_item(make_item(64'd7, 6'h2a, 8'h55), 1'b1);
    send_item(make_item(64'hffff_ffff_0000_0000, 6'h15, 8'haa), 1'b1);

    for (int i = 0; i < N_RANDOM; i++)
      send_item(make_item(rand_value(), rand_width(), $urandom_range(0, 255)),
                !(i >= QUIET_LO && i < QUIET_HI));

    @(negedge clk);
    start <= 1'b0;
    item  <= noise_item();

    // Drain, then give stray characters a chance to show.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/sitd_pkg.sv
src/sitd_bcd_cell.sv
src/sitd_bcd_chain.sv
src/signed_int_to_decimal_ascii_unit.sv
src/sitd_checker.sv
tb/sitd_scoreboard_pkg.sv
tb/tb_top.sv
